// File: hdl/mtg_pkg.sv
// Shared constants and types of the MT19937 word generator.
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int IDX_W        = 10;
  localparam int WORD_W       = 32;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd69069;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;
  localparam logic [WORD_W-1:0] TWIST_XOR    = 32'h9908b0df;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic              valid;
    logic              reseed;
    logic [WORD_W-1:0] seed;
  } head_t;

endpackage

// File: hdl/mtg_front.sv
// Command queue: takes input transfers and holds them for the back end.
module mtg_front #(
  parameter int DEPTH = mtg_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_mode,
  input  logic [mtg_pkg::WORD_W-1:0] in_seed_value,
  output mtg_pkg::head_t            head,
  input  logic                      pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                       mode_q [DEPTH];
  logic [mtg_pkg::WORD_W-1:0] seed_q [DEPTH];
  logic [PW-1:0]              wr_ptr_r;
  logic [PW-1:0]              rd_ptr_r;
  logic [CW-1:0]              count_r;
  logic                       push;

  assign in_ready    = (count_r != CW'(DEPTH));
  assign push        = in_valid && in_ready;
  assign head.valid  = (count_r != '0);
  assign head.reseed = mode_q[rd_ptr_r];
  assign head.seed   = seed_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mode_q[wr_ptr_r] <= in_mode;
      seed_q[wr_ptr_r] <= in_seed_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: hdl/mtg_back.sv
// Word table, seeding sequencer, in-place twist and tempered output register.
module mtg_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mtg_pkg::head_t             head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mtg_pkg::WORD_W-1:0] out_random_word
);

  localparam int IW = mtg_pkg::IDX_W;
  localparam int WW = mtg_pkg::WORD_W;
  localparam logic [IW-1:0] LAST_IDX  = IW'(mtg_pkg::STATE_WORDS - 1);
  localparam logic [IW-1:0] FAR_SPLIT = IW'(mtg_pkg::STATE_WORDS - mtg_pkg::TWIST_OFFSET);
  localparam logic [IW-1:0] FAR_ADD   = IW'(mtg_pkg::TWIST_OFFSET);

  typedef enum logic [1:0] {ST_IDLE, ST_SEED, ST_EXE} state_t;

  function automatic logic [WW-1:0] temper(input logic [WW-1:0] y);
    logic [WW-1:0] a;
    logic [WW-1:0] b;
    logic [WW-1:0] c;
    a = y ^ (y >> 11);
    b = a ^ ((a << 7) & mtg_pkg::TEMPER_B);
    c = b ^ ((b << 15) & mtg_pkg::TEMPER_C);
    return c ^ (c >> 18);
  endfunction

  logic [WW-1:0] mem [mtg_pkg::STATE_WORDS];

  state_t        state_r;
  logic [IW-1:0] pos_r;
  logic [IW-1:0] cnt_r;
  logic [WW-1:0] val_r;
  logic [WW-1:0] cur_r;
  logic          unseeded_r;
  logic          out_valid_r;
  logic [WW-1:0] out_word_r;
  logic [WW-1:0] rd_next_r;
  logic [WW-1:0] rd_far_r;

  logic          out_free;
  logic          load_out;
  logic          start_gen;
  logic          start_seed;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [WW-1:0] mem_wd;
  logic [IW-1:0] next_idx;
  logic [IW-1:0] far_idx;
  logic [WW-1:0] mix_y;
  logic [WW-1:0] twisted;

  assign out_free   = !out_valid_r || out_ready;
  assign load_out   = (state_r == ST_EXE) && out_free;
  assign start_seed = (state_r == ST_IDLE) && head.valid && (head.reseed || unseeded_r);
  assign start_gen  = (state_r == ST_IDLE) && head.valid && !head.reseed && !unseeded_r;
  assign pop        = start_gen || (start_seed && head.reseed);

  assign next_idx = (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;
  assign far_idx  = (pos_r < FAR_SPLIT) ? pos_r + FAR_ADD : pos_r - FAR_SPLIT;

  assign mix_y   = {cur_r[WW-1], rd_next_r[WW-2:0]};
  assign twisted = rd_far_r ^ (mix_y >> 1) ^ (mix_y[0] ? mtg_pkg::TWIST_XOR : '0);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = pos_r;
    mem_wd = twisted;
    case (state_r)
      ST_SEED: begin
        mem_we = 1'b1;
        mem_wa = cnt_r;
        mem_wd = val_r;
      end
      ST_EXE: begin
        mem_we = out_free;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (start_gen) begin
      rd_next_r <= mem[next_idx];
      rd_far_r  <= mem[far_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      unseeded_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (start_seed) begin
            val_r   <= head.reseed ? head.seed : mtg_pkg::DEFAULT_SEED;
            cur_r   <= head.reseed ? head.seed : mtg_pkg::DEFAULT_SEED;
            cnt_r   <= '0;
            state_r <= ST_SEED;
          end else if (start_gen) begin
            state_r <= ST_EXE;
          end
        end
        ST_SEED: begin
          val_r <= val_r * mtg_pkg::SEED_MULT;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_IDX) begin
            pos_r      <= '0;
            unseeded_r <= 1'b0;
            state_r    <= ST_IDLE;
          end
        end
        ST_EXE: begin
          if (out_free) begin
            out_word_r <= temper(twisted);
            cur_r      <= rd_next_r;
            pos_r      <= next_idx;
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_IDX)
    else $error("read position beyond table");

  a_exe_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXE && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("twist step did not load the output register");

  a_seed_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEED && cnt_r == LAST_IDX) |=> (!unseeded_r && pos_r == '0))
    else $error("seeding did not leave a fresh table");

  a_no_gen_unseeded: assert property (@(posedge clk) disable iff (!rst_n)
    start_gen |-> !unseeded_r)
    else $error("generate started on unseeded table");

endmodule

// File: hdl/mersenne_twister_generator.sv
// Top level of the MT19937 generator: command queue plus execution back end.
//
//  channel | direction | ports                                   | handshake
//  in      | input     | in_mode, in_seed_value                  | in_valid / in_ready
//  out     | output    | out_random_word                         | out_valid / out_ready
//
// A generate transfer in the back end is one table read (two ports) in the idle state,
// then twist of that word in place, write-back and tempering into the output register.
// A reseed is first taken from the queue, then the seeding multiplier gives one table
// write per cycle; a generate after reset seeds with 4357 first.
// Reset leaves the table unseeded and the queue empty; table contents are not cleared.
// A stalled output holds the back end in its twist step; the queue takes input until full.
module mersenne_twister_generator #(
  parameter int QUEUE_DEPTH = mtg_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_mode,
  input  logic [mtg_pkg::WORD_W-1:0] in_seed_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mtg_pkg::WORD_W-1:0] out_random_word
);

  mtg_pkg::head_t head;
  logic           pop;

  mtg_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_seed_value(in_seed_value),
    .head         (head),
    .pop          (pop)
  );

  mtg_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_random_word(out_random_word)
  );

endmodule
